### src/dms_pkg.sv
// Shared types and constants for the door motion state machine core.
package dms_pkg;

  typedef logic [3:0] state_code_t;
  typedef logic [3:0] led_pattern_t;  // bit 3 = led_one ... bit 0 = led_four

  localparam logic [7:0] BLINK_DIVIDE_RESET = 8'd10;

  localparam led_pattern_t LED_OFF     = 4'b0000;
  localparam led_pattern_t LED_ALL     = 4'b1111;
  localparam led_pattern_t LED_ACC_POS = 4'b0001;
  localparam led_pattern_t LED_ACC_NEG = 4'b0111;
  localparam led_pattern_t LED_MOVING  = 4'b0011;
  localparam led_pattern_t LED_DEC_POS = 4'b0111;
  localparam led_pattern_t LED_DEC_NEG = 4'b0001;

endpackage

### src/door_motion_state_machine_core.sv
// Door motion state machine: ten-state motion controller with blinking unknown indication.
// An accepted word has its result registered on the outputs from the next cycle.
// Throughput: one word per cycle while each result is taken; the motion state and blink counter update in one pass.
// A new word is taken whenever the result register is empty or being drained.
// Reset (rst, synchronous, active high): state init, blink counter and flag zero,
// blink_divide back to 10, no result pending.
module door_motion_state_machine_core (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [7:0]           cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 switch_one,
  input  logic                 switch_two,
  input  logic                 switch_three,
  input  logic                 switch_four,
  input  logic                 move_dir,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 led_one,
  output logic                 led_two,
  output logic                 led_three,
  output logic                 led_four,
  output dms_pkg::state_code_t door_state
);
  import dms_pkg::*;

  typedef enum logic [3:0] {
    ST_INIT    = 4'd0,
    ST_BLINK   = 4'd1,
    ST_OPEN    = 4'd2,
    ST_CLOSED  = 4'd3,
    ST_ACC_P   = 4'd4,
    ST_ACC_N   = 4'd5,
    ST_MOV_P   = 4'd6,
    ST_MOV_N   = 4'd7,
    ST_DEC_P   = 4'd8,
    ST_DEC_N   = 4'd9
  } motion_t;

  motion_t      state, state_next;
  logic [7:0]   blink_divide;
  logic [7:0]   blink_count, blink_count_next;
  logic         blink_flag, blink_flag_next;
  led_pattern_t leds;
  logic [7:0]   div_eff;
  logic [8:0]   count_inc;
  logic         accept;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  assign div_eff   = (blink_divide == 8'd0) ? 8'd1 : blink_divide;
  assign count_inc = {1'b0, blink_count} + 9'd1;

  always_comb begin
    state_next       = state;
    blink_count_next = blink_count;
    blink_flag_next  = blink_flag;
    leds             = LED_OFF;
    case (state)
      ST_INIT: begin
        state_next = ST_BLINK;
      end
      ST_BLINK: begin
        blink_flag_next  = (blink_count == 8'd0) ? !blink_flag : blink_flag;
        blink_count_next = (count_inc >= {1'b0, div_eff}) ? 8'd0 : count_inc[7:0];
        leds             = blink_flag_next ? LED_ALL : LED_OFF;
        if (switch_one && !move_dir) begin
          state_next = ST_OPEN;
        end else if (switch_four && move_dir) begin
          state_next = ST_CLOSED;
        end
      end
      ST_OPEN: begin
        if (move_dir) state_next = ST_ACC_P;
      end
      ST_CLOSED: begin
        leds = LED_ALL;
        if (!move_dir) state_next = ST_ACC_N;
      end
      ST_ACC_P: begin
        leds = LED_ACC_POS;
        if (switch_two) state_next = ST_MOV_P;
        else if (!move_dir) state_next = ST_DEC_N;
      end
      ST_ACC_N: begin
        leds = LED_ACC_NEG;
        if (switch_three) state_next = ST_MOV_N;
        else if (move_dir) state_next = ST_DEC_P;
      end
      ST_MOV_P: begin
        leds = LED_MOVING;
        if (switch_three) state_next = ST_DEC_P;
        else if (!move_dir) state_next = ST_MOV_N;
      end
      ST_MOV_N: begin
        leds = LED_MOVING;
        if (switch_two) state_next = ST_DEC_N;
        else if (move_dir) state_next = ST_MOV_P;
      end
      ST_DEC_P: begin
        leds = LED_DEC_POS;
        if (switch_four) state_next = ST_CLOSED;
        else if (!move_dir) state_next = ST_ACC_N;
      end
      ST_DEC_N: begin
        leds = LED_DEC_NEG;
        if (switch_one) state_next = ST_OPEN;
        else if (move_dir) state_next = ST_ACC_P;
      end
      default: begin
        leds       = LED_OFF;
        state_next = ST_INIT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_INIT;
      blink_count  <= 8'd0;
      blink_flag   <= 1'b0;
      blink_divide <= BLINK_DIVIDE_RESET;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_we) blink_divide <= cfg_wdata;
      if (accept) begin
        state       <= state_next;
        blink_count <= blink_count_next;
        blink_flag  <= blink_flag_next;
        out_valid   <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      led_one    <= leds[3];
      led_two    <= leds[2];
      led_three  <= leds[1];
      led_four   <= leds[0];
      door_state <= state_code_t'(state_next);
    end
  end

  a_accept_gives_result: assert property (@(posedge clk) disable iff (rst)
    accept |=> out_valid)
    else $error("accepted word produced no result");

  a_result_matches_state: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> door_state == state_code_t'(state))
    else $error("door_state disagrees with motion state");

  a_state_holds_when_idle: assert property (@(posedge clk) disable iff (rst)
    !accept |=> $stable(state) && $stable(blink_count) && $stable(blink_flag))
    else $error("state moved without an accepted word");

endmodule

### verif/tb_top.sv
// Self-checking testbench for door_motion_state_machine_core: scoreboard class plus handshake drivers.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import dms_pkg::*;

  localparam int CYCLE_LIMIT = 200000;

  typedef enum logic [3:0] {
    DS_INIT    = 4'd0,
    DS_UNKNOWN = 4'd1,
    DS_OPEN    = 4'd2,
    DS_CLOSED  = 4'd3,
    DS_ACC_POS = 4'd4,
    DS_ACC_NEG = 4'd5,
    DS_MOV_POS = 4'd6,
    DS_MOV_NEG = 4'd7,
    DS_DEC_POS = 4'd8,
    DS_DEC_NEG = 4'd9
  } door_state_e;

  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
    logic dir;
  } switch_word_t;

  typedef struct packed {
    led_pattern_t leds;
    state_code_t  st;
  } door_result_t;

  class door_checker;
    state_code_t  motion;
    logic [7:0]   count;
    logic         flag;
    logic [7:0]   divide;
    door_result_t pending[$];
    int           errors;
    int           checked;
    logic [15:0]  seen;

    function new();
      motion  = DS_INIT;
      count   = '0;
      flag    = 1'b0;
      divide  = BLINK_DIVIDE_RESET;
      errors  = 0;
      checked = 0;
      seen    = '0;
    endfunction

    // next LEDs and state for one accepted switch word
    function void take_word(switch_word_t w);
      door_result_t r;
      logic [7:0]   div;
      logic [8:0]   c;
      state_code_t  nxt;
      nxt    = motion;
      r.leds = LED_OFF;
      seen[motion] = 1'b1;
      case (motion)
        DS_INIT: begin
          nxt = DS_UNKNOWN;
        end
        DS_UNKNOWN: begin
          div = (divide == 8'd0) ? 8'd1 : divide;
          if (count == 8'd0) flag = ~flag;
          c = {1'b0, count} + 9'd1;
          if (c >= {1'b0, div}) c = '0;
          count  = c[7:0];
          r.leds = flag ? LED_ALL : LED_OFF;
          if (w.s1 && !w.dir) nxt = DS_OPEN;
          else if (w.s4 && w.dir) nxt = DS_CLOSED;
        end
        DS_OPEN: begin
          if (w.dir) nxt = DS_ACC_POS;
        end
        DS_CLOSED: begin
          r.leds = LED_ALL;
          if (!w.dir) nxt = DS_ACC_NEG;
        end
        DS_ACC_POS: begin
          r.leds = LED_ACC_POS;
          if (w.s2) nxt = DS_MOV_POS;
          else if (!w.dir) nxt = DS_DEC_NEG;
        end
        DS_ACC_NEG: begin
          r.leds = LED_ACC_NEG;
          if (w.s3) nxt = DS_MOV_NEG;
          else if (w.dir) nxt = DS_DEC_POS;
        end
        DS_MOV_POS: begin
          r.leds = LED_MOVING;
          if (w.s3) nxt = DS_DEC_POS;
          else if (!w.dir) nxt = DS_MOV_NEG;
        end
        DS_MOV_NEG: begin
          r.leds = LED_MOVING;
          if (w.s2) nxt = DS_DEC_NEG;
          else if (w.dir) nxt = DS_MOV_POS;
        end
        DS_DEC_POS: begin
          r.leds = LED_DEC_POS;
          if (w.s4) nxt = DS_CLOSED;
          else if (!w.dir) nxt = DS_ACC_NEG;
        end
        DS_DEC_NEG: begin
          r.leds = LED_DEC_NEG;
          if (w.s1) nxt = DS_OPEN;
          else if (w.dir) nxt = DS_ACC_POS;
        end
        default: begin
          nxt = DS_INIT;
        end
      endcase
      motion = nxt;
      r.st   = nxt;
      pending.push_back(r);
    endfunction

    task report(string what, int got, int want);
      if (errors < 40)
        $display("%0t mismatch on %s: got %0d, want %0d (result %0d)",
                 $realtime, what, got, want, checked);
      errors++;
    endtask

    task check_result(led_pattern_t leds, state_code_t st);
      door_result_t e;
      if (pending.size() == 0) begin
        report("unexpected result word", {leds, st}, 0);
        return;
      end
      e = pending.pop_front();
      checked++;
      if (leds !== e.leds) report("leds", leds, e.leds);
      if (st !== e.st) report("door_state", st, e.st);
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_we;
  logic [7:0]  cfg_wdata;
  logic        in_valid;
  logic        in_ready;
  logic        switch_one;
  logic        switch_two;
  logic        switch_three;
  logic        switch_four;
  logic        move_dir;
  logic        out_valid;
  logic        out_ready;
  logic        led_one;
  logic        led_two;
  logic        led_three;
  logic        led_four;
  state_code_t door_state;

  door_checker chk = new();

  int cycles     = 0;
  int n_words    = 0;
  int n_settings = 0;
  int burst_left = 0;
  int rx_tick    = 0;
  int rx_mode    = 0;

  door_motion_state_machine_core dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .switch_one   (switch_one),
    .switch_two   (switch_two),
    .switch_three (switch_three),
    .switch_four  (switch_four),
    .move_dir     (move_dir),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .led_one      (led_one),
    .led_two      (led_two),
    .led_three    (led_three),
    .led_four     (led_four),
    .door_state   (door_state)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      chk.check_result({led_one, led_two, led_three, led_four}, door_state);
  end

  // receiver stall pattern in one of four random modes, redrawn periodically
  always @(negedge clk) begin
    if (rx_tick % 96 == 0) rx_mode = $urandom_range(0, 3);
    rx_tick++;
    case (rx_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(0, 3) != 0);
      2: out_ready <= ($urandom_range(0, 3) == 0);
      default: out_ready <= ((rx_tick % 7) < 3);
    endcase
  end

  task automatic send_word(switch_word_t w);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_valid     <= 1'b1;
    switch_one   <= w.s1;
    switch_two   <= w.s2;
    switch_three <= w.s3;
    switch_four  <= w.s4;
    move_dir     <= w.dir;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    chk.take_word(w);
    n_words++;
  endtask

  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    burst_left = 0;
    while (chk.pending.size() != 0) @(posedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_divide(logic [7:0] v);
    settle();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    chk.divide = v;
    n_settings++;
  endtask

  // random word that keeps the door in the unknown state
  function automatic switch_word_t unknown_word();
    switch_word_t w;
    logic [4:0]   raw;
    raw = $urandom_range(0, 31);
    w   = raw;
    if (w.dir) w.s4 = 1'b0;
    else w.s1 = 1'b0;
    return w;
  endfunction

  function automatic switch_word_t any_word();
    logic [4:0] raw;
    raw = $urandom_range(0, 31);
    return raw;
  endfunction

  task automatic blink_phase(int n);
    repeat (n) send_word(unknown_word());
  endtask

  task automatic motion_phase(int n);
    repeat (n) send_word(any_word());
  endtask

  // walk through every motion transition, fields {s1,s2,s3,s4,dir}
  switch_word_t walk[] = '{
    5'b00000, 5'b00001, 5'b01000, 5'b00100, 5'b00010, 5'b11111, 5'b00000,
    5'b00101, 5'b01001, 5'b10001, 5'b00001, 5'b00000, 5'b00001, 5'b01001,
    5'b00000, 5'b00001, 5'b00101, 5'b00000, 5'b00001, 5'b00011
  };

  initial begin
    rst          <= 1'b1;
    cfg_we       <= 1'b0;
    cfg_wdata    <= '0;
    in_valid     <= 1'b0;
    switch_one   <= 1'b0;
    switch_two   <= 1'b0;
    switch_three <= 1'b0;
    switch_four  <= 1'b0;
    move_dir     <= 1'b0;
    out_ready    <= 1'b0;
    repeat (2) @(negedge clk);
    rst <= 1'b0;

    // init, then unknown-state words that must not leave it
    send_word(5'b11111);
    send_word(5'b11101);
    send_word(5'b01110);
    send_word(5'b00000);
    send_word(5'b10001);

    // blinking under several divides, reset value first
    blink_phase(40);
    write_divide(8'd0);
    blink_phase(20);
    write_divide(8'd1);
    blink_phase(20);
    write_divide(8'd255);
    blink_phase(300);
    write_divide(8'd5);     // below the running count
    blink_phase(30);
    write_divide(8'($urandom_range(2, 254)));
    blink_phase(60);

    send_word(5'b10000);    // open end reached
    foreach (walk[i]) send_word(walk[i]);

    motion_phase(350);
    write_divide(8'($urandom_range(1, 255)));
    motion_phase(350);
    write_divide(8'd255);
    motion_phase(350);
    write_divide(8'd1);
    motion_phase(350);

    settle();
    repeat (10) @(posedge clk);
    $display("sent %0d switch words, checked %0d results, %0d blink divide writes",
             n_words, chk.checked, n_settings);
    $display("door states stepped from: %b", chk.seen[9:0]);
    if (chk.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

### sim.f
src/dms_pkg.sv
src/door_motion_state_machine_core.sv
verif/tb_top.sv
